FILE: rtl/core/dfs_maze_carver_core_macros.svh
// Assertion macros for the maze carver core
`ifndef DFS_MAZE_CARVER_CORE_MACROS_SVH
`define DFS_MAZE_CARVER_CORE_MACROS_SVH
// implication checked on every clock edge outside reset
`define DMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define DMC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: rtl/core/dmc_pkg.sv
// Package for the maze carver: grid constants, opcodes, status codes, state type
package dmc_pkg;
    localparam int COLS = 32;
    localparam int ROWS = 32;
    localparam int NCELLS = COLS * ROWS;
    localparam int CW = $clog2(COLS);
    localparam int RW = $clog2(ROWS);
    localparam int AW = CW + RW;
    localparam int DW = AW + 1;

    typedef logic [AW-1:0] t_cell;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STEP  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] ST_CARVED = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_READ   = 2'd2;
    localparam logic [1:0] ST_START  = 2'd3;

    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_UP    = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    localparam logic [3:0] W_LEFT   = 4'b0001;
    localparam logic [3:0] W_TOP    = 4'b0010;
    localparam logic [3:0] W_RIGHT  = 4'b0100;
    localparam logic [3:0] W_BOTTOM = 4'b1000;

    typedef enum logic [4:0] {
        S_IDLE, S_CLEAR, S_START_FIX, S_RD_REQ, S_RD_WAIT,
        S_G_REQ, S_G_L, S_G_R, S_G_D, S_G_U, S_G_EVAL,
        S_POP_REQ, S_POP_WAIT, S_DIV, S_CARVE_F, S_CARVE_T, S_OUT
    } t_state;

    // memory commands issued by the controller
    typedef struct packed {
        logic       wall_rd;
        t_cell      wall_raddr;
        logic       wall_we;
        t_cell      wall_waddr;
        logic [3:0] wall_wdata;
        logic       vis_rd;
        t_cell      vis_raddr;
        logic       vis_we;
        t_cell      vis_waddr;
        logic       vis_wdata;
        logic       stk_rd;
        t_cell      stk_raddr;
        logic       stk_we;
        t_cell      stk_waddr;
        t_cell      stk_wdata;
    } t_mem_req;

    function automatic logic [CW-1:0] sat_col(input logic [4:0] c);
        if (int'(c) >= COLS) return CW'(COLS - 1);
        return CW'(c);
    endfunction

    function automatic logic [RW-1:0] sat_row(input logic [4:0] r);
        if (int'(r) >= ROWS) return RW'(ROWS - 1);
        return RW'(r);
    endfunction
endpackage

FILE: rtl/core/dmc_mem.sv
// Grid memories: wall store, visited map and path stack, with registered reads
module dmc_mem
    import dmc_pkg::*;
(
    input  logic       i_clk,
    input  t_mem_req   i_req,
    output logic [3:0] o_wall_rdata,
    output logic       o_vis_rdata,
    output t_cell      o_stk_rdata
);
    logic [3:0] r_wall [NCELLS];
    logic       r_vis  [NCELLS];
    t_cell      r_stk  [NCELLS];

    always_ff @(posedge i_clk) begin
        if (i_req.wall_we) r_wall[i_req.wall_waddr] <= i_req.wall_wdata;
        if (i_req.wall_rd) o_wall_rdata <= r_wall[i_req.wall_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.vis_we) r_vis[i_req.vis_waddr] <= i_req.vis_wdata;
        if (i_req.vis_rd) o_vis_rdata <= r_vis[i_req.vis_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.stk_we) r_stk[i_req.stk_waddr] <= i_req.stk_wdata;
        if (i_req.stk_rd) o_stk_rdata <= r_stk[i_req.stk_raddr];
    end
endmodule

FILE: rtl/core/dmc_ctrl.sv
// Sequencer: clear sweep, neighbor gather, backtrack pops, modulo, carve writes
module dmc_ctrl
    import dmc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_op,
    input  logic [4:0] i_start_col,
    input  logic [4:0] i_entrance_col,
    input  logic [4:0] i_exit_col,
    input  logic [14:0] i_rand_word,
    input  logic [4:0] i_cell_col,
    input  logic [4:0] i_cell_row,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_status,
    output logic [4:0] o_from_col,
    output logic [4:0] o_from_row,
    output logic [1:0] o_direction,
    output logic [3:0] o_walls,
    output t_mem_req   o_req,
    input  logic [3:0] i_wall_rdata,
    input  logic       i_vis_rdata,
    input  t_cell      i_stk_rdata
);
    `include "dfs_maze_carver_core_macros.svh"

    t_state r_state, n_state;
    logic [AW:0]   r_cnt, n_cnt;
    t_cell         r_cur, n_cur;
    logic [DW-1:0] r_sp, n_sp;
    logic          r_active, n_active;
    logic          r_boot, n_boot;   // clear sweep after reset, no start fix-up
    logic [3:0]    r_nb, n_nb;       // unvisited mask: left, right, down, up
    logic [14:0]   r_rem, n_rem;
    logic [2:0]    r_cntn, n_cntn;
    logic [1:0]    r_dir, n_dir;
    t_cell         r_to, n_to;
    logic [CW-1:0] r_s, n_s, r_e, n_e, r_x, n_x;
    logic [14:0]   r_rand, n_rand;
    t_cell         r_rdcell, n_rdcell;
    logic          r_ovalid, n_ovalid;
    logic [1:0]    r_status, n_status;
    logic [4:0]    r_fc, n_fc, r_fr, n_fr;
    logic [1:0]    r_odir, n_odir;
    logic [3:0]    r_owall, n_owall;

    logic [CW-1:0] cur_col;
    logic [RW-1:0] cur_row;
    logic [2:0]    nb_cnt;
    logic [1:0]    pick_idx;
    logic [1:0]    dir_list [4];
    logic [2:0]    k;
    logic [30:0]   mul3;
    logic [15:0]   q3x3;
    logic [1:0]    rem3;

    assign cur_col = r_cur[CW-1:0];
    assign cur_row = r_cur[AW-1:CW];
    assign nb_cnt  = 3'(r_nb[0]) + 3'(r_nb[1]) + 3'(r_nb[2]) + 3'(r_nb[3]);
    assign o_ready = (r_state == S_IDLE) && !r_ovalid;

    // mod 3 by reciprocal: floor(x/3) = (x * 0xAAAB) >> 17 for 15-bit x
    assign mul3 = 31'(r_rem) * 31'(16'hAAAB);
    assign q3x3 = {1'b0, mul3[30:17], 1'b0} + {2'b00, mul3[30:17]};
    assign rem3 = 2'({1'b0, r_rem} - q3x3);

    always_comb begin
        k = '0;
        for (int i = 0; i < 4; i++) dir_list[i] = DIR_LEFT;
        if (r_nb[0]) begin dir_list[k[1:0]] = DIR_LEFT;  k = k + 3'd1; end
        if (r_nb[1]) begin dir_list[k[1:0]] = DIR_RIGHT; k = k + 3'd1; end
        if (r_nb[2]) begin dir_list[k[1:0]] = DIR_DOWN;  k = k + 3'd1; end
        if (r_nb[3]) begin dir_list[k[1:0]] = DIR_UP;    k = k + 3'd1; end
        case (r_cntn)
            3'd2:    pick_idx = {1'b0, r_rem[0]};
            3'd3:    pick_idx = rem3;
            3'd4:    pick_idx = r_rem[1:0];
            default: pick_idx = 2'd0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    case (i_op)
                        OP_START: n_state = S_CLEAR;
                        OP_READ:  n_state = S_RD_REQ;
                        OP_STEP:  n_state = r_active ? S_G_REQ : S_OUT;
                        default:  n_state = S_OUT;
                    endcase
                end
            end
            S_CLEAR: begin
                if (r_cnt == (AW+1)'(NCELLS - 1)) n_state = r_boot ? S_IDLE : S_START_FIX;
            end
            S_START_FIX: if (r_cnt[0]) n_state = S_OUT;
            S_RD_REQ:    n_state = S_RD_WAIT;
            S_RD_WAIT:   n_state = S_OUT;
            S_G_REQ:     n_state = S_G_L;
            S_G_L:       n_state = S_G_R;
            S_G_R:       n_state = S_G_D;
            S_G_D:       n_state = S_G_U;
            S_G_U:       n_state = S_G_EVAL;
            S_G_EVAL: begin
                if (nb_cnt != 3'd0) n_state = S_DIV;
                else if (r_sp == '0) n_state = S_OUT;
                else n_state = S_POP_REQ;
            end
            S_POP_REQ:   n_state = S_POP_WAIT;
            S_POP_WAIT:  n_state = S_G_REQ;
            S_DIV:       n_state = S_CARVE_F;
            S_CARVE_F:   n_state = S_CARVE_T;
            S_CARVE_T:   n_state = S_OUT;
            S_OUT:       n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // datapath and memory commands
    always_comb begin
        n_cnt = r_cnt; n_cur = r_cur; n_sp = r_sp; n_active = r_active; n_boot = r_boot;
        n_nb = r_nb; n_rem = r_rem; n_cntn = r_cntn; n_dir = r_dir; n_to = r_to;
        n_s = r_s; n_e = r_e; n_x = r_x; n_rand = r_rand;
        n_rdcell = r_rdcell; n_ovalid = r_ovalid; n_status = r_status;
        n_fc = r_fc; n_fr = r_fr; n_odir = r_odir; n_owall = r_owall;
        o_req = '0;
        if (r_ovalid && i_ready) n_ovalid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_cnt = '0;
                    n_s = sat_col(i_start_col);
                    n_e = sat_col(i_entrance_col);
                    n_x = sat_col(i_exit_col);
                    n_rand = i_rand_word;
                    n_rdcell = {sat_row(i_cell_row), sat_col(i_cell_col)};
                    n_status = ST_IDLE; n_fc = '0; n_fr = '0; n_odir = '0; n_owall = '0;
                end
            end
            S_CLEAR: begin
                o_req.wall_we = 1'b1; o_req.wall_waddr = r_cnt[AW-1:0];
                o_req.wall_wdata = 4'hF;
                o_req.vis_we = 1'b1; o_req.vis_waddr = r_cnt[AW-1:0];
                o_req.vis_wdata = !r_boot && (r_cnt[AW-1:0] == AW'(r_s));
                if (r_cnt == (AW+1)'(NCELLS - 1)) begin
                    n_cnt = '0;
                    n_boot = 1'b0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_START_FIX: begin
                // entrance and exit may be the same cell only when ROWS is 1
                o_req.wall_we = 1'b1;
                if (!r_cnt[0]) begin
                    o_req.wall_waddr = AW'(r_e);
                    o_req.wall_wdata = 4'hF & ~W_BOTTOM;
                end else begin
                    o_req.wall_waddr = {RW'(ROWS - 1), r_x};
                    o_req.wall_wdata = 4'hF & ~W_TOP;
                    n_cur = AW'(r_s); n_sp = '0; n_active = 1'b1;
                    n_status = ST_START;
                end
                n_cnt = r_cnt + 1'b1;
            end
            S_RD_REQ: begin
                o_req.wall_rd = 1'b1; o_req.wall_raddr = r_rdcell;
            end
            S_RD_WAIT: begin
                n_status = ST_READ;
                n_fc = 5'(r_rdcell[CW-1:0]); n_fr = 5'(r_rdcell[AW-1:CW]);
                n_owall = i_wall_rdata;
            end
            S_G_REQ: begin
                o_req.vis_rd = 1'b1; o_req.vis_raddr = r_cur - 1'b1;
            end
            S_G_L: begin
                n_nb[0] = (cur_col != '0) && !i_vis_rdata;
                o_req.vis_rd = 1'b1; o_req.vis_raddr = r_cur + 1'b1;
            end
            S_G_R: begin
                n_nb[1] = (cur_col != CW'(COLS - 1)) && !i_vis_rdata;
                o_req.vis_rd = 1'b1; o_req.vis_raddr = r_cur - AW'(COLS);
            end
            S_G_D: begin
                n_nb[2] = (cur_row != '0) && !i_vis_rdata;
                o_req.vis_rd = 1'b1; o_req.vis_raddr = r_cur + AW'(COLS);
            end
            S_G_U: begin
                n_nb[3] = (cur_row != RW'(ROWS - 1)) && !i_vis_rdata;
            end
            S_G_EVAL: begin
                n_rem = r_rand; n_cntn = nb_cnt;
                if (nb_cnt == 3'd0 && r_sp == '0) n_active = 1'b0;
            end
            S_POP_REQ: begin
                o_req.stk_rd = 1'b1; o_req.stk_raddr = r_sp[AW-1:0] - 1'b1;
                n_sp = r_sp - 1'b1;
            end
            S_POP_WAIT: n_cur = i_stk_rdata;
            S_DIV: begin
                n_dir = dir_list[pick_idx];
                case (dir_list[pick_idx])
                    DIR_LEFT:  n_to = r_cur - 1'b1;
                    DIR_RIGHT: n_to = r_cur + 1'b1;
                    DIR_DOWN:  n_to = r_cur - AW'(COLS);
                    default:   n_to = r_cur + AW'(COLS);
                endcase
                o_req.wall_rd = 1'b1; o_req.wall_raddr = r_cur;
            end
            S_CARVE_F: begin
                o_req.wall_we = 1'b1; o_req.wall_waddr = r_cur;
                case (r_dir)
                    DIR_LEFT:  o_req.wall_wdata = i_wall_rdata & ~W_LEFT;
                    DIR_RIGHT: o_req.wall_wdata = i_wall_rdata & ~W_RIGHT;
                    DIR_DOWN:  o_req.wall_wdata = i_wall_rdata & ~W_BOTTOM;
                    default:   o_req.wall_wdata = i_wall_rdata & ~W_TOP;
                endcase
                o_req.wall_rd = 1'b1; o_req.wall_raddr = r_to;
                o_req.stk_we = (r_sp != DW'(NCELLS)); o_req.stk_waddr = r_sp[AW-1:0];
                o_req.stk_wdata = r_cur;
                if (r_sp != DW'(NCELLS)) n_sp = r_sp + 1'b1;
                o_req.vis_we = 1'b1; o_req.vis_waddr = r_to; o_req.vis_wdata = 1'b1;
            end
            S_CARVE_T: begin
                o_req.wall_we = 1'b1; o_req.wall_waddr = r_to;
                case (r_dir)
                    DIR_LEFT:  o_req.wall_wdata = i_wall_rdata & ~W_RIGHT;
                    DIR_RIGHT: o_req.wall_wdata = i_wall_rdata & ~W_LEFT;
                    DIR_DOWN:  o_req.wall_wdata = i_wall_rdata & ~W_TOP;
                    default:   o_req.wall_wdata = i_wall_rdata & ~W_BOTTOM;
                endcase
                n_status = ST_CARVED; n_odir = r_dir;
                n_fc = 5'(cur_col); n_fr = 5'(cur_row);
                n_cur = r_to;
            end
            S_OUT: n_ovalid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_cnt <= '0; r_cur <= '0; r_sp <= '0;
            r_active <= 1'b0; r_ovalid <= 1'b0; r_boot <= 1'b1;
        end else begin
            r_state <= n_state; r_cnt <= n_cnt; r_cur <= n_cur; r_sp <= n_sp;
            r_active <= n_active; r_ovalid <= n_ovalid; r_boot <= n_boot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nb <= n_nb; r_rem <= n_rem; r_cntn <= n_cntn; r_dir <= n_dir; r_to <= n_to;
        r_s <= n_s; r_e <= n_e; r_x <= n_x; r_rand <= n_rand;
        r_rdcell <= n_rdcell; r_status <= n_status; r_fc <= n_fc; r_fr <= n_fr;
        r_odir <= n_odir; r_owall <= n_owall;
    end

    assign o_valid     = r_ovalid;
    assign o_status    = r_status;
    assign o_from_col  = r_fc;
    assign o_from_row  = r_fr;
    assign o_direction = r_odir;
    assign o_walls     = r_owall;

    `DMC_ASSERT_IMP(a_sp_range, i_clk, i_rst_n, 1'b1, r_sp <= DW'(NCELLS))
    `DMC_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, !o_ready)
    `DMC_ASSERT_NXT(a_out_once, i_clk, i_rst_n, r_state == S_OUT, r_ovalid && r_state == S_IDLE)
    `DMC_ASSERT_IMP(a_div_nonzero, i_clk, i_rst_n, r_state == S_DIV, r_cntn != 3'd0)
endmodule

FILE: rtl/core/dfs_maze_carver_core.sv
// Maze carver top level: DFS backtracker over on-chip grid memories
// Usage: one input channel (i_valid/o_ready) carries an op per beat: start,
// carve step or cell read. Every accepted beat yields exactly one result beat
// on the output channel (o_valid/i_ready).
// Start runs a clear sweep over every cell, then the entrance and exit fixes.
// A read fetches the walls of one cell. A carve step gathers the unvisited
// neighbors, popping the stack to backtrack while there are none, then
// carves toward one of them; a step that finds the walk exhausted returns a
// result without carving. The visited-map port, read once per neighbor, sets
// the gather time.
// One item is in flight at a time; the next beat is taken the cycle after
// the result has been taken.
// If the receiver stalls, the result holds in the output register and no new
// input is accepted.
// Reset clears control state (no walk active, stack empty, no result pending)
// and starts a clearing pass over every cell that sets every wall and clears
// every visited mark; o_ready stays low until it is done.
module dfs_maze_carver_core
    import dmc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [4:0]  i_start_col,
    input  logic [4:0]  i_entrance_col,
    input  logic [4:0]  i_exit_col,
    input  logic [14:0] i_rand_word,
    input  logic [4:0]  i_cell_col,
    input  logic [4:0]  i_cell_row,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [4:0]  o_from_col,
    output logic [4:0]  o_from_row,
    output logic [1:0]  o_direction,
    output logic        o_wall_left,
    output logic        o_wall_top,
    output logic        o_wall_right,
    output logic        o_wall_bottom
);
    t_mem_req   mem_req;
    logic [3:0] wall_rdata;
    logic       vis_rdata;
    t_cell      stk_rdata;
    logic [3:0] walls;

    dmc_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_op, .i_start_col, .i_entrance_col,
        .i_exit_col, .i_rand_word, .i_cell_col, .i_cell_row, .o_valid, .i_ready,
        .o_status, .o_from_col, .o_from_row, .o_direction,
        .o_walls(walls), .o_req(mem_req),
        .i_wall_rdata(wall_rdata), .i_vis_rdata(vis_rdata), .i_stk_rdata(stk_rdata)
    );

    dmc_mem u_mem (
        .i_clk, .i_req(mem_req),
        .o_wall_rdata(wall_rdata), .o_vis_rdata(vis_rdata), .o_stk_rdata(stk_rdata)
    );

    assign o_wall_left   = walls[0];
    assign o_wall_top    = walls[1];
    assign o_wall_right  = walls[2];
    assign o_wall_bottom = walls[3];
endmodule
